// ----- sv/per_flow_frame_aggregation_scheduler_macros.svh -----
// Assertion helpers; the enclosing module provides clk and rst_n.
`ifndef PER_FLOW_FRAME_AGGREGATION_SCHEDULER_MACROS_SVH
`define PER_FLOW_FRAME_AGGREGATION_SCHEDULER_MACROS_SVH

// Same-cycle implication.
`define PFFAS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PFFAS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/pffas_pkg.sv -----
package pffas_pkg;

    localparam int FLOWS_DEF       = 16;
    localparam int FRAME_SLOTS_DEF = 32;

    localparam int OP_W     = 2;
    localparam int DEST_W   = 48;
    localparam int KIND_W   = 4;
    localparam int LEN_W    = 14;
    localparam int TAG_W    = 16;
    localparam int STATUS_W = 3;
    localparam int BYTES_W  = 20;
    localparam int HDR_W    = 10;
    localparam int TICK_W   = 32;
    localparam int PEND_W   = 16;
    localparam int STAMP_W  = 33;
    localparam int AGE_W    = 34;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
    localparam logic [OP_W-1:0] OP_RETX = 2'd1;
    localparam logic [OP_W-1:0] OP_SEND = 2'd2;
    localparam logic [OP_W-1:0] OP_TICK = 2'd3;

    localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DROP_LIM = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_ROOM  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MEMBER   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NONE     = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RETX_AGE  = 3'd4;

    localparam logic [BYTES_W-1:0] THRESHOLD_RST = 20'd1500;
    localparam logic [TICK_W-1:0]  MAX_AGE_RST   = 32'd1000;
    localparam logic [BYTES_W-1:0] LIMIT_RST     = 20'd65536;
    localparam logic [TICK_W-1:0]  RETX_AGE_RST  = 32'd1000;

    // header sizes: aggregated mode base + per subframe, plain mode per frame
    localparam logic [HDR_W-1:0] HDR_AGG_BASE = 10'd40;
    localparam logic [HDR_W-1:0] HDR_AGG_SUB  = 10'd16;
    localparam logic [HDR_W-1:0] HDR_PLAIN    = 10'd24;

    // slot record: stamp, length, tag
    localparam int SD_W = STAMP_W + LEN_W + TAG_W;

endpackage

// ----- sv/pffas_if.sv -----
interface pffas_in_if;
    import pffas_pkg::*;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [DEST_W-1:0] dest_address;
    logic [KIND_W-1:0] traffic_kind;
    logic [LEN_W-1:0]  frame_length;
    logic [TAG_W-1:0]  frame_tag;
    modport source (output valid, opcode, dest_address, traffic_kind, frame_length,
                    frame_tag, input ready);
    modport sink (input valid, opcode, dest_address, traffic_kind, frame_length,
                  frame_tag, output ready);
endinterface

interface pffas_out_if;
    import pffas_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [DEST_W-1:0]   dest_address_res;
    logic [KIND_W-1:0]   traffic_kind_res;
    logic [TAG_W-1:0]    frame_tag_res;
    logic [LEN_W-1:0]    frame_length_res;
    logic [BYTES_W-1:0]  aggregate_bytes;
    logic [HDR_W-1:0]    header_bytes;
    logic                last;
    modport source (output valid, status, dest_address_res, traffic_kind_res,
                    frame_tag_res, frame_length_res, aggregate_bytes, header_bytes,
                    last, input ready);
    modport sink (input valid, status, dest_address_res, traffic_kind_res,
                  frame_tag_res, frame_length_res, aggregate_bytes, header_bytes,
                  last, output ready);
endinterface

interface pffas_cfg_if;
    import pffas_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/pffas_ram.sv -----
module pffas_ram #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 1,
    parameter int AW    = 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    wa,
    input  logic [WIDTH-1:0] wd,
    input  logic [AW-1:0]    ra,
    output logic [WIDTH-1:0] rd
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd <= mem[ra];
    end
endmodule

// ----- sv/per_flow_frame_aggregation_scheduler.sv -----
// Channel  | Dir | Handshake    | Request carries
// ---------+-----+--------------+-------------------------------------------------
// in_req   | in  | valid/ready  | opcode, dest_address, traffic_kind, length, tag
// out_res  | out | valid/ready  | status, dest/kind/tag/length, sums, last
// cfg      | in  | valid/ready  | register index, write data (always ready)
//
// One request at a time; in_req.ready is high only while the sequencer is idle.
// Tick: handled in the idle state. Enqueue: serial flow/slot scan through the flow RAM read
// port, then a send attempt if a request is pending and the frame was accepted.
// Send: scan of every flow slot, with a list walk on the slot RAM port for each occupied
// one, then the members are popped one at a time, each held in emit while out_res stalls.
// Reset clears control state at once.
// A stall on out_res holds the sequencer in its emit state; nothing is lost.
`include "per_flow_frame_aggregation_scheduler_macros.svh"

module per_flow_frame_aggregation_scheduler #(
    parameter int FLOWS       = pffas_pkg::FLOWS_DEF,
    parameter int FRAME_SLOTS = pffas_pkg::FRAME_SLOTS_DEF
) (
    input logic         clk,
    input logic         rst_n,
    pffas_in_if.sink    in_req,
    pffas_out_if.source out_res,
    pffas_cfg_if.sink   cfg
);
    import pffas_pkg::*;

    localparam int FW     = (FLOWS > 1) ? $clog2(FLOWS) : 1;
    localparam int SW     = $clog2(FRAME_SLOTS);
    localparam int CW     = $clog2(FRAME_SLOTS + 1);
    localparam int SCAN_N = (FLOWS > FRAME_SLOTS) ? FLOWS : FRAME_SLOTS;
    localparam int XW     = $clog2(SCAN_N + 1);
    localparam int FID_W  = DEST_W + KIND_W;

    typedef enum logic [4:0] {
        S_IDLE, S_EMIT,
        S_ENQ_CHECK, S_ENQ_RD, S_ENQ_CMP, S_ENQ_DECIDE, S_ENQ_LINK_RD, S_ENQ_LINK,
        S_ENQ_LINK2,
        S_SC_START, S_SC_FLOW, S_SC_HEAD, S_SC_SRD, S_SC_SACC, S_SC_EVAL,
        S_SEND_DECIDE, S_POP_FRD, S_POP_FDAT, S_POP_CHK, S_POP_DAT, S_POP_END
    } state_t;

    // sequencer and configuration
    state_t state_reg, state_next, ret_reg, ret_next;
    logic [BYTES_W-1:0] thr_reg, thr_next, limit_reg, limit_next;
    logic [TICK_W-1:0]  max_age_reg, max_age_next, retx_reg, retx_next;
    logic               mode_reg, mode_next;

    // global state
    logic [TICK_W-1:0]  now_reg, now_next;
    logic [PEND_W-1:0]  pend_reg, pend_next;
    logic [BYTES_W-1:0] total_reg, total_next;
    logic [FLOWS-1:0]       fvalid_reg, fvalid_next;
    logic [CW-1:0]          fcount_reg [FLOWS];
    logic [CW-1:0]          fcount_next [FLOWS];
    logic [FRAME_SLOTS-1:0] sused_reg, sused_next;

    // request latch
    logic [OP_W-1:0]   op_reg, op_next;
    logic [DEST_W-1:0] dest_reg, dest_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [TAG_W-1:0]  tag_reg, tag_next;

    // scan / walk / pop working registers
    logic [XW-1:0] idx_reg, idx_next;
    logic          fl_found_reg, fl_found_next, freef_found_reg, freef_found_next;
    logic          frees_found_reg, frees_found_next, best_found_reg, best_found_next;
    logic [FW-1:0] fl_reg, fl_next, freef_reg, freef_next, best_reg, best_next;
    logic [FW-1:0] sel_f_reg, sel_f_next;
    logic [SW-1:0] frees_reg, frees_next, cur_s_reg, cur_s_next, tail_reg, tail_next;
    logic [CW-1:0] walk_n_reg, walk_n_next;
    logic [BYTES_W-1:0] bsum_reg, bsum_next, agg_reg, agg_next;
    logic signed [AGE_W-1:0] age_reg, age_next, best_age_reg, best_age_next;
    logic [HDR_W-1:0] hdr_reg, hdr_next;

    // result register
    logic [STATUS_W-1:0] o_status_reg, o_status_next;
    logic [DEST_W-1:0]   o_dest_reg, o_dest_next;
    logic [KIND_W-1:0]   o_kind_reg, o_kind_next;
    logic [TAG_W-1:0]    o_tag_reg, o_tag_next;
    logic [LEN_W-1:0]    o_len_reg, o_len_next;
    logic [BYTES_W-1:0]  o_agg_reg, o_agg_next;
    logic [HDR_W-1:0]    o_hdr_reg, o_hdr_next;
    logic                o_last_reg, o_last_next;

    // RAM ports
    logic [FW-1:0]    f_ra;
    logic             fid_we, fhd_we, ftl_we, sd_we, snx_we;
    logic [FID_W-1:0] fid_rd;
    logic [SW-1:0]    fhd_rd, ftl_rd, snx_rd, snx_wa, snx_wd, fhd_wd;
    logic [SD_W-1:0]  sd_rd, sd_wd;

    logic [STAMP_W-1:0] sd_stamp;
    logic [LEN_W-1:0]   sd_len;
    logic [TAG_W-1:0]   sd_tag;
    logic signed [AGE_W-1:0] age_d;
    logic [STAMP_W-1:0] stamp_new;
    logic [BYTES_W-1:0] agg_sum;
    logic [CW-1:0]      cnt_sel;
    logic               s_in_range;

    assign sd_stamp = sd_rd[SD_W-1 -: STAMP_W];
    assign sd_len   = sd_rd[TAG_W +: LEN_W];
    assign sd_tag   = sd_rd[TAG_W-1:0];
    // age of the frame just read: now minus its signed stamp
    assign age_d    = signed'({2'b00, now_reg}) - signed'({sd_stamp[STAMP_W-1], sd_stamp});
    assign stamp_new = (op_reg == OP_RETX) ? ({1'b0, now_reg} - {1'b0, retx_reg})
                                           : {1'b0, now_reg};
    assign agg_sum  = agg_reg + BYTES_W'(sd_len);
    assign cnt_sel  = fcount_reg[sel_f_reg];
    assign s_in_range = ({1'b0, cur_s_reg} < (SW+1)'(FRAME_SLOTS));
    assign sd_wd    = {stamp_new, len_reg, tag_reg};

    assign in_req.ready = (state_reg == S_IDLE);
    assign cfg.ready    = 1'b1;
    assign out_res.valid            = (state_reg == S_EMIT);
    assign out_res.status           = o_status_reg;
    assign out_res.dest_address_res = o_dest_reg;
    assign out_res.traffic_kind_res = o_kind_reg;
    assign out_res.frame_tag_res    = o_tag_reg;
    assign out_res.frame_length_res = o_len_reg;
    assign out_res.aggregate_bytes  = o_agg_reg;
    assign out_res.header_bytes     = o_hdr_reg;
    assign out_res.last             = o_last_reg;

    // flow RAM read address: scan index while scanning, else the selected flow
    always_comb
    begin
        f_ra = sel_f_reg;
        if (state_reg == S_ENQ_RD || state_reg == S_SC_FLOW)
        begin
            f_ra = idx_reg[FW-1:0];
        end
    end

    // flow identity, head and tail; slot record and link
    pffas_ram #(.DEPTH(FLOWS), .WIDTH(FID_W), .AW(FW)) u_fid (
        .clk(clk), .we(fid_we), .wa(freef_reg), .wd({dest_reg, kind_reg}),
        .ra(f_ra), .rd(fid_rd));
    pffas_ram #(.DEPTH(FLOWS), .WIDTH(SW), .AW(FW)) u_fhd (
        .clk(clk), .we(fhd_we), .wa(sel_f_reg), .wd(fhd_wd), .ra(f_ra), .rd(fhd_rd));
    pffas_ram #(.DEPTH(FLOWS), .WIDTH(SW), .AW(FW)) u_ftl (
        .clk(clk), .we(ftl_we), .wa(sel_f_reg), .wd(frees_reg), .ra(f_ra), .rd(ftl_rd));
    pffas_ram #(.DEPTH(FRAME_SLOTS), .WIDTH(SD_W), .AW(SW)) u_sd (
        .clk(clk), .we(sd_we), .wa(frees_reg), .wd(sd_wd), .ra(cur_s_reg), .rd(sd_rd));
    pffas_ram #(.DEPTH(FRAME_SLOTS), .WIDTH(SW), .AW(SW)) u_snx (
        .clk(clk), .we(snx_we), .wa(snx_wa), .wd(snx_wd), .ra(cur_s_reg), .rd(snx_rd));

    always_comb
    begin
        state_next = state_reg;   ret_next = ret_reg;
        thr_next = thr_reg;       limit_next = limit_reg;
        max_age_next = max_age_reg; retx_next = retx_reg; mode_next = mode_reg;
        now_next = now_reg;       pend_next = pend_reg;   total_next = total_reg;
        fvalid_next = fvalid_reg; fcount_next = fcount_reg; sused_next = sused_reg;
        op_next = op_reg; dest_next = dest_reg; kind_next = kind_reg;
        len_next = len_reg; tag_next = tag_reg;
        idx_next = idx_reg;
        fl_found_next = fl_found_reg; freef_found_next = freef_found_reg;
        frees_found_next = frees_found_reg; best_found_next = best_found_reg;
        fl_next = fl_reg; freef_next = freef_reg; best_next = best_reg;
        sel_f_next = sel_f_reg; frees_next = frees_reg; cur_s_next = cur_s_reg;
        tail_next = tail_reg; walk_n_next = walk_n_reg; bsum_next = bsum_reg;
        agg_next = agg_reg; age_next = age_reg; best_age_next = best_age_reg;
        hdr_next = hdr_reg;
        o_status_next = o_status_reg; o_dest_next = o_dest_reg; o_kind_next = o_kind_reg;
        o_tag_next = o_tag_reg; o_len_next = o_len_reg; o_agg_next = o_agg_reg;
        o_hdr_next = o_hdr_reg; o_last_next = o_last_reg;
        fid_we = 1'b0; fhd_we = 1'b0; ftl_we = 1'b0; sd_we = 1'b0; snx_we = 1'b0;
        fhd_wd = frees_reg; snx_wa = frees_reg; snx_wd = frees_reg;

        // configuration writes are to arrive only while idle; the block itself does not enforce this
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_THRESHOLD: thr_next     = cfg.data[BYTES_W-1:0];
                CFG_MAX_AGE:   max_age_next = cfg.data[TICK_W-1:0];
                CFG_LIMIT:     limit_next   = cfg.data[BYTES_W-1:0];
                CFG_MODE:      mode_next    = cfg.data[0];
                CFG_RETX_AGE:  retx_next    = cfg.data[TICK_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_req.valid)
                begin
                    op_next   = in_req.opcode;
                    dest_next = in_req.dest_address;
                    kind_next = in_req.traffic_kind;
                    len_next  = in_req.frame_length;
                    tag_next  = in_req.frame_tag;
                    unique case (in_req.opcode)
                        OP_TICK: now_next = now_reg + 1'b1;
                        OP_SEND:
                        begin
                            if (pend_reg != '1)
                            begin
                                pend_next = pend_reg + 1'b1;
                            end
                            state_next = S_SC_START;
                        end
                        default: state_next = S_ENQ_CHECK;
                    endcase
                end
            end

            S_EMIT:
            begin
                if (out_res.ready)
                begin
                    state_next = ret_reg;
                end
            end

            // ---- enqueue ----
            S_ENQ_CHECK:
            begin
                o_dest_next = dest_reg; o_kind_next = kind_reg;
                o_tag_next = tag_reg;   o_len_next = len_reg;
                o_agg_next = '0; o_hdr_next = '0; o_last_next = 1'b0;
                if (total_reg >= limit_reg)
                begin
                    o_status_next = ST_DROP_LIM;
                    ret_next = S_IDLE;
                    state_next = S_EMIT;
                end
                else
                begin
                    idx_next = '0;
                    fl_found_next = 1'b0; freef_found_next = 1'b0; frees_found_next = 1'b0;
                    state_next = S_ENQ_RD;
                end
            end

            S_ENQ_RD: state_next = S_ENQ_CMP;

            S_ENQ_CMP:
            begin
                if (idx_reg < XW'(FLOWS))
                begin
                    if (fvalid_reg[idx_reg[FW-1:0]])
                    begin
                        if (!fl_found_reg && fid_rd == {dest_reg, kind_reg})
                        begin
                            fl_found_next = 1'b1;
                            fl_next = idx_reg[FW-1:0];
                        end
                    end
                    else if (!freef_found_reg)
                    begin
                        freef_found_next = 1'b1;
                        freef_next = idx_reg[FW-1:0];
                    end
                end
                if (idx_reg < XW'(FRAME_SLOTS) && !frees_found_reg
                    && !sused_reg[idx_reg[SW-1:0]])
                begin
                    frees_found_next = 1'b1;
                    frees_next = idx_reg[SW-1:0];
                end
                if (idx_reg == XW'(SCAN_N - 1))
                begin
                    state_next = S_ENQ_DECIDE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = S_ENQ_RD;
                end
            end

            S_ENQ_DECIDE:
            begin
                if (!frees_found_reg || (!fl_found_reg && !freef_found_reg))
                begin
                    o_status_next = ST_NO_ROOM;
                    ret_next = S_IDLE;
                    state_next = S_EMIT;
                end
                else
                begin
                    if (!fl_found_reg)
                    begin
                        fvalid_next[freef_reg] = 1'b1;
                        fcount_next[freef_reg] = '0;
                        fid_we = 1'b1;
                        sel_f_next = freef_reg;
                    end
                    else
                    begin
                        sel_f_next = fl_reg;
                    end
                    sused_next[frees_reg] = 1'b1;
                    sd_we = 1'b1;
                    state_next = S_ENQ_LINK_RD;
                end
            end

            S_ENQ_LINK_RD: state_next = S_ENQ_LINK;

            S_ENQ_LINK:
            begin
                // retransmit goes in front of the head, a new frame behind the tail
                snx_we = 1'b1;
                snx_wd = (op_reg == OP_RETX) ? fhd_rd : frees_reg;
                fhd_we = (op_reg == OP_RETX) || (cnt_sel == '0);
                ftl_we = (op_reg != OP_RETX) || (cnt_sel == '0);
                tail_next = ftl_rd;
                fcount_next[sel_f_reg] = cnt_sel + 1'b1;
                total_next = total_reg + BYTES_W'(len_reg);
                o_status_next = ST_ACCEPTED;
                ret_next = (pend_reg != '0) ? S_SC_START : S_IDLE;
                state_next = (op_reg != OP_RETX && cnt_sel != '0) ? S_ENQ_LINK2 : S_EMIT;
            end

            S_ENQ_LINK2:
            begin
                snx_we = 1'b1;
                snx_wa = tail_reg;
                state_next = S_EMIT;
            end

            // ---- scan for the oldest eligible flow ----
            S_SC_START:
            begin
                idx_next = '0;
                best_found_next = 1'b0;
                state_next = S_SC_FLOW;
            end

            S_SC_FLOW:
            begin
                if (!fvalid_reg[idx_reg[FW-1:0]] || fcount_reg[idx_reg[FW-1:0]] == '0)
                begin
                    if (idx_reg == XW'(FLOWS - 1))
                    begin
                        state_next = S_SEND_DECIDE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    state_next = S_SC_HEAD;
                end
            end

            S_SC_HEAD:
            begin
                cur_s_next = fhd_rd;
                walk_n_next = '0; bsum_next = '0; age_next = '0;
                state_next = S_SC_SRD;
            end

            S_SC_SRD: state_next = s_in_range ? S_SC_SACC : S_SC_EVAL;

            S_SC_SACC:
            begin
                bsum_next = bsum_reg + BYTES_W'(sd_len);
                if (age_d > age_reg)
                begin
                    age_next = age_d;
                end
                cur_s_next = snx_rd;
                walk_n_next = walk_n_reg + 1'b1;
                state_next = (walk_n_reg + 1'b1 == fcount_reg[idx_reg[FW-1:0]])
                             ? S_SC_EVAL : S_SC_SRD;
            end

            S_SC_EVAL:
            begin
                if (bsum_reg != '0
                    && (bsum_reg >= thr_reg || age_reg >= signed'({2'b00, max_age_reg}))
                    && (!best_found_reg || age_reg > best_age_reg))
                begin
                    best_found_next = 1'b1;
                    best_age_next = age_reg;
                    best_next = idx_reg[FW-1:0];
                end
                if (idx_reg == XW'(FLOWS - 1))
                begin
                    state_next = S_SEND_DECIDE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = S_SC_FLOW;
                end
            end

            // ---- pop the winner ----
            S_SEND_DECIDE:
            begin
                if (best_found_reg)
                begin
                    sel_f_next = best_reg;
                    agg_next = '0;
                    hdr_next = mode_reg ? HDR_AGG_BASE : '0;
                    state_next = S_POP_FRD;
                end
                else if (op_reg == OP_SEND)
                begin
                    o_status_next = ST_NONE;
                    o_dest_next = '0; o_kind_next = '0; o_tag_next = '0; o_len_next = '0;
                    o_agg_next = '0; o_hdr_next = '0; o_last_next = 1'b0;
                    ret_next = S_IDLE;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_POP_FRD: state_next = S_POP_FDAT;

            S_POP_FDAT:
            begin
                dest_next = fid_rd[FID_W-1 -: DEST_W];
                kind_next = fid_rd[KIND_W-1:0];
                cur_s_next = fhd_rd;
                state_next = S_POP_CHK;
            end

            S_POP_CHK:
            begin
                if (cnt_sel == '0 || (agg_reg >= thr_reg && agg_reg != '0) || !s_in_range)
                begin
                    state_next = S_POP_END;
                end
                else
                begin
                    state_next = S_POP_DAT;
                end
            end

            S_POP_DAT:
            begin
                agg_next = agg_sum;
                hdr_next = hdr_reg + (mode_reg ? HDR_AGG_SUB : HDR_PLAIN);
                total_next = total_reg - BYTES_W'(sd_len);
                sused_next[cur_s_reg] = 1'b0;
                cur_s_next = snx_rd;
                fcount_next[sel_f_reg] = cnt_sel - 1'b1;
                o_status_next = ST_MEMBER;
                o_dest_next = dest_reg; o_kind_next = kind_reg;
                o_tag_next = sd_tag;    o_len_next = sd_len;
                o_agg_next = agg_sum;
                o_hdr_next = hdr_reg + (mode_reg ? HDR_AGG_SUB : HDR_PLAIN);
                o_last_next = (cnt_sel == CW'(1)) || (agg_sum >= thr_reg && agg_sum != '0);
                ret_next = S_POP_CHK;
                state_next = S_EMIT;
            end

            S_POP_END:
            begin
                fhd_we = 1'b1;
                fhd_wd = cur_s_reg;
                if (cnt_sel == '0)
                begin
                    fvalid_next[sel_f_reg] = 1'b0;
                end
                if (pend_reg != '0)
                begin
                    pend_next = pend_reg - 1'b1;
                end
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;     ret_reg <= S_IDLE;
            thr_reg <= THRESHOLD_RST; max_age_reg <= MAX_AGE_RST;
            limit_reg <= LIMIT_RST;  mode_reg <= 1'b1;  retx_reg <= RETX_AGE_RST;
            now_reg <= '0; pend_reg <= '0; total_reg <= '0;
            fvalid_reg <= '0; sused_reg <= '0;
            for (int i = 0; i < FLOWS; i++)
            begin
                fcount_reg[i] <= '0;
            end
            op_reg <= OP_ENQ; dest_reg <= '0; kind_reg <= '0; len_reg <= '0; tag_reg <= '0;
            idx_reg <= '0;
            fl_found_reg <= 1'b0; freef_found_reg <= 1'b0;
            frees_found_reg <= 1'b0; best_found_reg <= 1'b0;
            fl_reg <= '0; freef_reg <= '0; best_reg <= '0; sel_f_reg <= '0;
            frees_reg <= '0; cur_s_reg <= '0; tail_reg <= '0; walk_n_reg <= '0;
            bsum_reg <= '0; agg_reg <= '0; age_reg <= '0; best_age_reg <= '0; hdr_reg <= '0;
            o_status_reg <= ST_ACCEPTED; o_dest_reg <= '0; o_kind_reg <= '0;
            o_tag_reg <= '0; o_len_reg <= '0; o_agg_reg <= '0; o_hdr_reg <= '0;
            o_last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next; ret_reg <= ret_next;
            thr_reg <= thr_next; max_age_reg <= max_age_next;
            limit_reg <= limit_next; mode_reg <= mode_next; retx_reg <= retx_next;
            now_reg <= now_next; pend_reg <= pend_next; total_reg <= total_next;
            fvalid_reg <= fvalid_next; fcount_reg <= fcount_next; sused_reg <= sused_next;
            op_reg <= op_next; dest_reg <= dest_next; kind_reg <= kind_next;
            len_reg <= len_next; tag_reg <= tag_next;
            idx_reg <= idx_next;
            fl_found_reg <= fl_found_next; freef_found_reg <= freef_found_next;
            frees_found_reg <= frees_found_next; best_found_reg <= best_found_next;
            fl_reg <= fl_next; freef_reg <= freef_next; best_reg <= best_next;
            sel_f_reg <= sel_f_next;
            frees_reg <= frees_next; cur_s_reg <= cur_s_next; tail_reg <= tail_next;
            walk_n_reg <= walk_n_next;
            bsum_reg <= bsum_next; agg_reg <= agg_next; age_reg <= age_next;
            best_age_reg <= best_age_next; hdr_reg <= hdr_next;
            o_status_reg <= o_status_next; o_dest_reg <= o_dest_next;
            o_kind_reg <= o_kind_next; o_tag_reg <= o_tag_next; o_len_reg <= o_len_next;
            o_agg_reg <= o_agg_next; o_hdr_reg <= o_hdr_next; o_last_reg <= o_last_next;
        end
    end

    // a result is never shown while a new request could enter
    `PFFAS_ASSERT_NOW(a_emit_blocks_input, out_res.valid, !in_req.ready, "input open during emit")
    // an accepted request other than a tick keeps the block busy
    `PFFAS_ASSERT_NEXT(a_busy_after_req, in_req.valid && in_req.ready && in_req.opcode != OP_TICK, !in_req.ready, "ready after request")
    // a member frame is always inside its running payload sum
    `PFFAS_ASSERT_NOW(a_member_sum, out_res.valid && out_res.status == ST_MEMBER, BYTES_W'(out_res.frame_length_res) <= out_res.aggregate_bytes, "member length above running sum")
endmodule
